// File: rtl/core/bmp_stream_pixel_decoder_defines.svh
// Assertion macros for the BMP pixel decoder checker.
`ifndef BMP_STREAM_PIXEL_DECODER_DEFINES_SVH
`define BMP_STREAM_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define BMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bmp decoder check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define BMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bmp decoder check failed");

`endif

// File: rtl/core/bmp_pkg.sv
// Package: types, codes and constants of the BMP pixel decoder.
package bmp_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] SIG_B        = 8'h42;
    localparam logic [7:0] SIG_M        = 8'h4D;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic       KIND_PIXEL  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FORMAT    = 3'd1;
    localparam logic [2:0] ST_SIGNATURE = 3'd2;
    localparam logic [2:0] ST_DEPTH     = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } bmp_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic [2:0]  status;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last;
    } bmp_out_t;

    typedef struct packed {
        logic        has_pixel;
        logic        has_status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic [2:0]  status;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } bmp_entry_t;

    typedef struct packed {
        logic       valid;
        bmp_entry_t entry;
    } bmp_slot_t;

endpackage

// File: rtl/core/bmp_front.sv
// Front end: header parser and pixel assembler, one byte per cycle while in_fire is high.
module bmp_front #(
    parameter int MAX_WIDTH  = bmp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmp_pkg::MAX_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  bmp_pkg::bmp_in_t  in_item,
    input  logic              cfg_fire,
    input  logic              cfg_alpha,
    output bmp_pkg::bmp_slot_t push
);
    import bmp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    localparam logic [5:0] HDR_SIG0   = 6'd0;
    localparam logic [5:0] HDR_SIG1   = 6'd1;
    localparam logic [5:0] HDR_WIDTH  = 6'd18;
    localparam logic [5:0] HDR_HEIGHT = 6'd22;
    localparam logic [5:0] HDR_DEPTH  = 6'd28;
    localparam logic [5:0] HDR_LAST   = 6'd53;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXELS,
        PH_PADDING,
        PH_DONE
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [5:0]      hpos_reg, hpos_next;
    logic            sig_ok_reg, sig_ok_next;
    logic [7:0]      depth_reg, depth_next;
    logic [31:0]     width_reg, width_next;
    logic [31:0]     height_reg, height_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [1:0]      bip_reg, bip_next;
    logic [7:0]      blue_reg, blue_next;
    logic [7:0]      green_reg, green_next;
    logic [7:0]      red_reg, red_next;
    logic [1:0]      pad_reg, pad_next;
    logic            alpha_en_reg;

    logic [7:0]      b;
    logic            is32;
    logic [1:0]      final_byte;
    logic [1:0]      hidx_w, hidx_h;
    logic [CW-1:0]   col_inc;
    logic [31:0]     col_wide, row_wide;
    logic [1:0]      pad_amt;
    bmp_slot_t       push_next;

    assign b          = in_item.data_byte;
    assign is32       = (depth_reg == DEPTH_32);
    assign final_byte = is32 ? 2'd3 : 2'd2;
    assign hidx_w     = 2'(hpos_reg - HDR_WIDTH);
    assign hidx_h     = 2'(hpos_reg - HDR_HEIGHT);
    assign col_inc    = col_reg + CW'(1);
    assign col_wide   = 32'(col_reg);
    assign row_wide   = 32'(row_reg);
    assign pad_amt    = is32 ? 2'd0 : width_reg[1:0];

    always_comb begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        sig_ok_next = sig_ok_reg;
        depth_next  = depth_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bip_next    = bip_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        red_next    = red_reg;
        pad_next    = pad_reg;
        push_next   = '0;

        if (in_fire) begin
            if (in_item.end_of_file) begin
                if (phase_reg != PH_DONE) begin
                    push_next.valid            = 1'b1;
                    push_next.entry.has_status = 1'b1;
                    push_next.entry.status     = ST_FORMAT;
                end
                phase_next  = PH_HEADER;
                hpos_next   = '0;
                sig_ok_next = 1'b1;
                depth_next  = '0;
                width_next  = '0;
                height_next = '0;
                col_next    = '0;
                row_next    = '0;
                bip_next    = '0;
                blue_next   = '0;
                green_next  = '0;
                red_next    = '0;
                pad_next    = '0;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (hpos_reg == HDR_SIG0 && b != SIG_B) begin
                            sig_ok_next = 1'b0;
                        end
                        if (hpos_reg == HDR_SIG1 && b != SIG_M) begin
                            sig_ok_next = 1'b0;
                        end
                        if (hpos_reg == HDR_DEPTH) begin
                            depth_next = b;
                        end
                        if (hpos_reg >= HDR_WIDTH && hpos_reg < HDR_HEIGHT) begin
                            width_next[{hidx_w, 3'b000} +: 8] = b;
                        end
                        if (hpos_reg >= HDR_HEIGHT && hpos_reg < HDR_HEIGHT + 6'd4) begin
                            height_next[{hidx_h, 3'b000} +: 8] = b;
                        end
                        hpos_next = hpos_reg + 6'd1;
                        if (hpos_reg == HDR_LAST) begin
                            if (!sig_ok_reg) begin
                                push_next.valid            = 1'b1;
                                push_next.entry.has_status = 1'b1;
                                push_next.entry.status     = ST_SIGNATURE;
                                phase_next                 = PH_DONE;
                            end else if (depth_reg != DEPTH_24 && depth_reg != DEPTH_32) begin
                                push_next.valid            = 1'b1;
                                push_next.entry.has_status = 1'b1;
                                push_next.entry.status     = ST_DEPTH;
                                phase_next                 = PH_DONE;
                            end else if (width_reg > 32'(MAX_WIDTH)
                                         || height_reg > 32'(MAX_HEIGHT)) begin
                                push_next.valid            = 1'b1;
                                push_next.entry.has_status = 1'b1;
                                push_next.entry.status     = ST_TOO_LARGE;
                                phase_next                 = PH_DONE;
                            end else if (width_reg == '0 || height_reg == '0) begin
                                push_next.valid              = 1'b1;
                                push_next.entry.has_status   = 1'b1;
                                push_next.entry.status       = ST_OK;
                                push_next.entry.image_width  = width_reg[12:0];
                                push_next.entry.image_height = height_reg[12:0];
                                phase_next                   = PH_DONE;
                            end else begin
                                phase_next = PH_PIXELS;
                                col_next   = '0;
                                row_next   = RW'(height_reg - 32'd1);
                                bip_next   = '0;
                            end
                        end
                    end
                    PH_PIXELS: begin
                        case (bip_reg)
                            2'd0:    blue_next  = b;
                            2'd1:    green_next = b;
                            2'd2:    red_next   = b;
                            default: ;
                        endcase
                        if (bip_reg >= final_byte) begin
                            push_next.valid           = 1'b1;
                            push_next.entry.has_pixel = 1'b1;
                            push_next.entry.red       = (bip_reg == 2'd2) ? b : red_reg;
                            push_next.entry.green     = green_reg;
                            push_next.entry.blue      = blue_reg;
                            push_next.entry.alpha     = alpha_en_reg ? ALPHA_OPAQUE : 8'd0;
                            push_next.entry.column    = col_wide[11:0];
                            push_next.entry.row       = row_wide[11:0];
                            bip_next                  = '0;
                            col_next                  = col_inc;
                            if (32'(col_inc) >= width_reg) begin
                                col_next = '0;
                                if (pad_amt != 2'd0) begin
                                    phase_next = PH_PADDING;
                                    pad_next   = pad_amt;
                                end else if (row_reg == '0) begin
                                    push_next.entry.has_status   = 1'b1;
                                    push_next.entry.status       = ST_OK;
                                    push_next.entry.image_width  = width_reg[12:0];
                                    push_next.entry.image_height = height_reg[12:0];
                                    phase_next                   = PH_DONE;
                                end else begin
                                    row_next = row_reg - RW'(1);
                                end
                            end
                        end else begin
                            bip_next = bip_reg + 2'd1;
                        end
                    end
                    PH_PADDING: begin
                        if (pad_reg != 2'd0) begin
                            pad_next = pad_reg - 2'd1;
                        end
                        if (pad_reg <= 2'd1) begin
                            if (row_reg == '0) begin
                                push_next.valid              = 1'b1;
                                push_next.entry.has_status   = 1'b1;
                                push_next.entry.status       = ST_OK;
                                push_next.entry.image_width  = width_reg[12:0];
                                push_next.entry.image_height = height_reg[12:0];
                                phase_next                   = PH_DONE;
                            end else begin
                                row_next   = row_reg - RW'(1);
                                phase_next = PH_PIXELS;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hpos_reg     <= '0;
            sig_ok_reg   <= 1'b1;
            depth_reg    <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            bip_reg      <= '0;
            blue_reg     <= '0;
            green_reg    <= '0;
            red_reg      <= '0;
            pad_reg      <= '0;
            alpha_en_reg <= 1'b1;
            push         <= '0;
        end else begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            sig_ok_reg <= sig_ok_next;
            depth_reg  <= depth_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            red_reg    <= red_next;
            pad_reg    <= pad_next;
            push       <= push_next;
            if (cfg_fire) begin
                alpha_en_reg <= cfg_alpha;
            end
        end
    end

endmodule

// File: rtl/core/bmp_queue.sv
// Short queue of decoded entries between the front end and the back end.
module bmp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmp_pkg::bmp_slot_t push,
    input  logic               pop,
    output bmp_pkg::bmp_slot_t head,
    output logic               full
);
    import bmp_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    bmp_entry_t    mem_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]   count_reg, count_next;
    logic          do_pop;

    // the entry registered in the front end still counts against the space
    assign do_pop     = pop && (count_reg != '0);
    assign full       = ((count_reg + (QW+1)'(push.valid)) >= (QW+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + (QW+1)'(1);
            2'b01:   count_next = count_reg - (QW+1)'(1);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + QW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/bmp_back.sv
// Back end: expands queued entries into result items behind an output register.
module bmp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmp_pkg::bmp_slot_t head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output bmp_pkg::bmp_out_t  m_data
);
    import bmp_pkg::*;

    logic     m_valid_reg;
    bmp_out_t m_data_reg;
    logic     sent_pixel_reg;
    logic     load;
    bmp_out_t result;

    assign load = head.valid && (!m_valid_reg || m_ready);

    always_comb begin
        result = '0;
        if (head.entry.has_pixel && !sent_pixel_reg) begin
            result.kind   = KIND_PIXEL;
            result.red    = head.entry.red;
            result.green  = head.entry.green;
            result.blue   = head.entry.blue;
            result.alpha  = head.entry.alpha;
            result.column = head.entry.column;
            result.row    = head.entry.row;
            result.last   = !head.entry.has_status;
        end else begin
            result.kind         = KIND_STATUS;
            result.status       = head.entry.status;
            result.image_width  = head.entry.image_width;
            result.image_height = head.entry.image_height;
            result.last         = 1'b1;
        end
    end

    assign pop     = load && result.last;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result;
        end
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            sent_pixel_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg    <= 1'b1;
                sent_pixel_reg <= !result.last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/bmp_stream_pixel_decoder.sv
// Top level of the streaming 24/32-bit BMP pixel decoder.
// Throughput: one byte per cycle; s_ready drops only when the four-entry queue,
// counting the entry still in the front register, is full.
// A result item passes through the front push register, the queue and the output register.
// When no row padding follows, the byte that ends the image gives a pixel and a status result from one queue entry.
// Reset (aresetn low, synchronous): parser rearmed, queue emptied, alpha_enable set to 1.
module bmp_stream_pixel_decoder #(
    parameter int MAX_WIDTH  = bmp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmp_pkg::MAX_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmp_pkg::bmp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bmp_pkg::bmp_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import bmp_pkg::*;

    bmp_slot_t push;
    bmp_slot_t head;
    logic      q_full;
    logic      pop;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;

    bmp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .in_item   (s_data),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_alpha (cfg_data),
        .push      (push)
    );

    bmp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (q_full)
    );

    bmp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/bmp_checker.sv
// Port-level checker for the BMP pixel decoder, bound to the top level.
`include "bmp_stream_pixel_decoder_defines.svh"

module bmp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input bmp_pkg::bmp_out_t m_data
);
    import bmp_pkg::*;

    logic px_out;
    logic st_out;
    logic size_zero;
    logic pixel_zero;

    assign px_out     = m_valid && m_data.kind == KIND_PIXEL;
    assign st_out     = m_valid && m_data.kind == KIND_STATUS;
    assign size_zero  = m_data.image_width == '0 && m_data.image_height == '0;
    assign pixel_zero = m_data.red == '0 && m_data.green == '0 && m_data.blue == '0
                        && m_data.alpha == '0 && m_data.column == '0 && m_data.row == '0;

    `BMP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `BMP_ASSERT_SAME(a_status_last, st_out, m_data.last)
    `BMP_ASSERT_SAME(a_pixel_clean, px_out, m_data.status == ST_OK && size_zero)
    `BMP_ASSERT_SAME(a_status_clean, st_out, pixel_zero)
    `BMP_ASSERT_SAME(a_error_size, st_out && m_data.status != ST_OK, size_zero)

endmodule

bind bmp_stream_pixel_decoder bmp_checker u_bmp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
